// ----- src/uktab_pkg.sv -----
// Shared codes, types and defaults for the unsorted key table.
`timescale 1ns / 1ps

package uktab_pkg;

  // Default sizes of the table.
  localparam int DEPTH_DEF  = 16;
  localparam int ITEM_W_DEF = 16;

  // Fixed port widths.
  localparam int OP_W      = 4;
  localparam int KEY_W     = 16;
  localparam int ST_W      = 3;
  localparam int CNT_OUT_W = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT   = 4'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP   = 4'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 4'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 4'd3;
  localparam logic [OP_W-1:0] OP_CUR_RST  = 4'd4;
  localparam logic [OP_W-1:0] OP_READ     = 4'd5;
  localparam logic [OP_W-1:0] OP_SPLIT    = 4'd6;
  localparam logic [OP_W-1:0] OP_INS_UNIQ = 4'd7;
  localparam logic [OP_W-1:0] OP_DEL_ALL  = 4'd8;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_MISS  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_END   = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd4;
  localparam logic [ST_W-1:0] ST_DUP   = 3'd5;

  // Source of the value field of a result word.
  typedef enum logic [1:0] {
    V_ZERO,
    V_KEY,
    V_RDATA
  } vsel_e;

  // Kind of table write.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_APPEND_IN,
    WR_APPEND_KEY,
    WR_SWAP
  } wsel_e;

  // Read address selection; the scan index follows the address for START and NEXT.
  typedef enum logic [2:0] {
    RS_HOLD,
    RS_START,
    RS_NEXT,
    RS_TAIL,
    RS_CURSOR
  } rsel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            ld_key;
    logic            emit;
    logic [ST_W-1:0] status;
    vsel_e           vsel;
    logic            side_en;
    logic            last;
    wsel_e           wsel;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            cnt_clr;
    logic            cur_clr;
    logic            cur_inc;
    logic            cur_to_cnt;
    rsel_e           rsel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic last;
    logic cnt_zero;
    logic full;
    logic cur_end;
  } stat_t;

endpackage

// ----- src/unsorted_key_table.sv -----
// Top level of the unsorted key table: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
// - Command word: op_i and key_value_i are taken at a rising edge where start is
//   high and busy is low. busy is high while a multi-cycle operation runs.
// - Result words: each is shown for one cycle with result_strobe_o high; the
//   receiver cannot stall, so every word must be taken as it comes.
//   last_result_o marks the final word of a command; only split gives more
//   than one word (one per stored entry, in table order).
// - entry_count_o, is_full_o and is_empty_o show the table state after the op.
// - Sequencing: insert, clear, cursor reset, unknown ops and immediate misses
//   give their word the cycle after acceptance and a new command may follow at
//   once. Read next fetches the entry at the cursor and gives it from S_READ.
//   Lookup, delete, insert unique and split walk the stored entries one per
//   cycle through the registered read port of the entry memory; a delete that
//   hits then moves the last entry into the hole in state S_TAIL. Delete all
//   moves the last entry into each hole and re-reads the filled hole in
//   S_RESUME before the scan goes on.
// - Reset (rst_ni low, asynchronous) empties the table and puts the read cursor
//   before the first entry; the entry memory itself needs no clearing.

module unsorted_key_table #(
  parameter int DEPTH      = uktab_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = uktab_pkg::ITEM_W_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [uktab_pkg::OP_W-1:0]      op_i,
  input  logic [uktab_pkg::KEY_W-1:0]     key_value_i,
  output logic                            result_strobe_o,
  output logic [uktab_pkg::ST_W-1:0]      status_o,
  output logic [uktab_pkg::KEY_W-1:0]     item_value_o,
  output logic                            split_side_o,
  output logic                            last_result_o,
  output logic [uktab_pkg::CNT_OUT_W-1:0] entry_count_o,
  output logic                            is_full_o,
  output logic                            is_empty_o
);

  uktab_pkg::cmd_t  cmd;
  uktab_pkg::stat_t stat;

  uktab_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .op_i  (op_i),
    .stat_i(stat),
    .cmd_o (cmd),
    .busy  (busy)
  );

  uktab_dp #(
    .DEPTH     (DEPTH),
    .ITEM_WIDTH(ITEM_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .key_value_i    (key_value_i),
    .stat_o         (stat),
    .result_strobe_o(result_strobe_o),
    .status_o       (status_o),
    .item_value_o   (item_value_o),
    .split_side_o   (split_side_o),
    .last_result_o  (last_result_o),
    .entry_count_o  (entry_count_o),
    .is_full_o      (is_full_o),
    .is_empty_o     (is_empty_o)
  );

endmodule

// ----- src/uktab_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module uktab_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/uktab_ctrl.sv -----
// Controller state machine that sequences each table operation.
`timescale 1ns / 1ps

module uktab_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic [uktab_pkg::OP_W-1:0] op_i,
  input  uktab_pkg::stat_t          stat_i,
  output uktab_pkg::cmd_t           cmd_o,
  output logic                      busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_TAIL   = 3'd2;
  localparam logic [2:0] S_RESUME = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [uktab_pkg::OP_W-1:0] op_q, op_d;
  logic                       hit_q, hit_d;
  logic                       accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    hit_d   = hit_q;
    cmd_o   = '0;
    cmd_o.last = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d         = op_i;
          hit_d        = 1'b0;
          cmd_o.ld_key = 1'b1;
          unique case (op_i) inside
            uktab_pkg::OP_INSERT: begin
              cmd_o.emit = 1'b1;
              if (stat_i.full) begin
                cmd_o.status = uktab_pkg::ST_FULL;
              end else begin
                cmd_o.status  = uktab_pkg::ST_OK;
                cmd_o.wsel    = uktab_pkg::WR_APPEND_IN;
                cmd_o.cnt_inc = 1'b1;
              end
            end
            uktab_pkg::OP_LOOKUP, uktab_pkg::OP_DELETE, uktab_pkg::OP_DEL_ALL: begin
              if (stat_i.cnt_zero) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = uktab_pkg::ST_MISS;
              end else begin
                cmd_o.rsel = uktab_pkg::RS_START;
                state_d    = S_SCAN;
              end
            end
            uktab_pkg::OP_CLEAR: begin
              cmd_o.emit    = 1'b1;
              cmd_o.status  = uktab_pkg::ST_OK;
              cmd_o.cnt_clr = 1'b1;
            end
            uktab_pkg::OP_CUR_RST: begin
              cmd_o.emit    = 1'b1;
              cmd_o.status  = uktab_pkg::ST_OK;
              cmd_o.cur_clr = 1'b1;
            end
            uktab_pkg::OP_READ: begin
              if (stat_i.cur_end) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = uktab_pkg::ST_END;
              end else begin
                cmd_o.rsel = uktab_pkg::RS_CURSOR;
                state_d    = S_READ;
              end
            end
            uktab_pkg::OP_SPLIT: begin
              if (stat_i.cnt_zero) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = uktab_pkg::ST_EMPTY;
              end else begin
                cmd_o.rsel = uktab_pkg::RS_START;
                state_d    = S_SCAN;
              end
            end
            uktab_pkg::OP_INS_UNIQ: begin
              // An empty table holds no duplicate and always has room.
              if (stat_i.cnt_zero) begin
                cmd_o.emit    = 1'b1;
                cmd_o.status  = uktab_pkg::ST_OK;
                cmd_o.wsel    = uktab_pkg::WR_APPEND_IN;
                cmd_o.cnt_inc = 1'b1;
              end else begin
                cmd_o.rsel = uktab_pkg::RS_START;
                state_d    = S_SCAN;
              end
            end
            default: begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = uktab_pkg::ST_OK;
            end
          endcase
        end
      end

      // One stored entry is compared per cycle while the next read is issued.
      S_SCAN: begin
        unique case (op_q) inside
          uktab_pkg::OP_SPLIT: begin
            cmd_o.emit    = 1'b1;
            cmd_o.status  = uktab_pkg::ST_OK;
            cmd_o.vsel    = uktab_pkg::V_RDATA;
            cmd_o.side_en = 1'b1;
            cmd_o.last    = stat_i.last;
            if (stat_i.last) begin
              cmd_o.cur_to_cnt = 1'b1;
              state_d          = S_IDLE;
            end else begin
              cmd_o.rsel = uktab_pkg::RS_NEXT;
            end
          end
          uktab_pkg::OP_LOOKUP: begin
            if (stat_i.match) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = uktab_pkg::ST_OK;
              cmd_o.vsel   = uktab_pkg::V_KEY;
              state_d      = S_IDLE;
            end else if (stat_i.last) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = uktab_pkg::ST_MISS;
              state_d      = S_IDLE;
            end else begin
              cmd_o.rsel = uktab_pkg::RS_NEXT;
            end
          end
          uktab_pkg::OP_INS_UNIQ: begin
            if (stat_i.match) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = uktab_pkg::ST_DUP;
              cmd_o.vsel   = uktab_pkg::V_KEY;
              state_d      = S_IDLE;
            end else if (stat_i.last) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
              if (stat_i.full) begin
                cmd_o.status = uktab_pkg::ST_FULL;
              end else begin
                cmd_o.status  = uktab_pkg::ST_OK;
                cmd_o.wsel    = uktab_pkg::WR_APPEND_KEY;
                cmd_o.cnt_inc = 1'b1;
              end
            end else begin
              cmd_o.rsel = uktab_pkg::RS_NEXT;
            end
          end
          uktab_pkg::OP_DELETE, uktab_pkg::OP_DEL_ALL: begin
            if (stat_i.match) begin
              hit_d      = 1'b1;
              cmd_o.rsel = uktab_pkg::RS_TAIL;
              state_d    = S_TAIL;
            end else if (stat_i.last) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
              if (hit_q) begin
                cmd_o.status = uktab_pkg::ST_OK;
                cmd_o.vsel   = uktab_pkg::V_KEY;
              end else begin
                cmd_o.status = uktab_pkg::ST_MISS;
              end
            end else begin
              cmd_o.rsel = uktab_pkg::RS_NEXT;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      // The last entry is on the read port: move it into the hole.
      S_TAIL: begin
        cmd_o.wsel    = uktab_pkg::WR_SWAP;
        cmd_o.cnt_dec = 1'b1;
        if ((op_q == uktab_pkg::OP_DEL_ALL) && !stat_i.last) begin
          state_d = S_RESUME;
        end else begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = uktab_pkg::ST_OK;
          cmd_o.vsel   = uktab_pkg::V_KEY;
          state_d      = S_IDLE;
        end
      end

      // Re-read the filled hole before the scan goes on.
      S_RESUME: begin
        cmd_o.rsel = uktab_pkg::RS_HOLD;
        state_d    = S_SCAN;
      end

      S_READ: begin
        cmd_o.emit    = 1'b1;
        cmd_o.status  = uktab_pkg::ST_OK;
        cmd_o.vsel    = uktab_pkg::V_RDATA;
        cmd_o.cur_inc = 1'b1;
        state_d       = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= uktab_pkg::OP_INSERT;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      hit_q   <= hit_d;
    end
  end

endmodule

// ----- src/uktab_dp.sv -----
// Datapath: entry memory, count, cursor, scan index and result register.
`timescale 1ns / 1ps

module uktab_dp #(
  parameter int DEPTH      = uktab_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = uktab_pkg::ITEM_W_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  uktab_pkg::cmd_t                 cmd_i,
  input  logic [uktab_pkg::KEY_W-1:0]     key_value_i,
  output uktab_pkg::stat_t                stat_o,
  output logic                            result_strobe_o,
  output logic [uktab_pkg::ST_W-1:0]      status_o,
  output logic [uktab_pkg::KEY_W-1:0]     item_value_o,
  output logic                            split_side_o,
  output logic                            last_result_o,
  output logic [uktab_pkg::CNT_OUT_W-1:0] entry_count_o,
  output logic                            is_full_o,
  output logic                            is_empty_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ITEM_WIDTH-1:0] key_in, key_q;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         cursor_q, cursor_d;
  logic [CW-1:0]         cidx_q, cidx_d, cidx_nx, count_m1;
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [ITEM_WIDTH-1:0] wdata, rdata;

  logic                           strobe_q;
  logic [uktab_pkg::ST_W-1:0]     status_q;
  logic [uktab_pkg::KEY_W-1:0]    value_q, value_d;
  logic                           side_q;
  logic                           last_q;

  assign key_in   = ITEM_WIDTH'(key_value_i);
  assign cidx_nx  = cidx_q + CW'(1);
  assign count_m1 = count_q - CW'(1);

  // Read address and scan index.
  always_comb begin
    raddr  = cidx_q[AW-1:0];
    cidx_d = cidx_q;
    unique case (cmd_i.rsel)
      uktab_pkg::RS_HOLD:   raddr = cidx_q[AW-1:0];
      uktab_pkg::RS_START: begin
        raddr  = '0;
        cidx_d = '0;
      end
      uktab_pkg::RS_NEXT: begin
        raddr  = cidx_nx[AW-1:0];
        cidx_d = cidx_nx;
      end
      uktab_pkg::RS_TAIL:   raddr = count_m1[AW-1:0];
      uktab_pkg::RS_CURSOR: raddr = cursor_q[AW-1:0];
      default:              raddr = cidx_q[AW-1:0];
    endcase
  end

  // Table writes: append at the count, or fill a hole at the scan index.
  always_comb begin
    we    = 1'b1;
    waddr = count_q[AW-1:0];
    wdata = key_in;
    unique case (cmd_i.wsel)
      uktab_pkg::WR_NONE:       we = 1'b0;
      uktab_pkg::WR_APPEND_IN:  wdata = key_in;
      uktab_pkg::WR_APPEND_KEY: wdata = key_q;
      uktab_pkg::WR_SWAP: begin
        waddr = cidx_q[AW-1:0];
        wdata = rdata;
      end
      default: we = 1'b0;
    endcase
  end

  uktab_ram #(
    .WIDTH(ITEM_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Count and cursor updates.
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_m1;
    end

    cursor_d = cursor_q;
    if (cmd_i.cur_clr) begin
      cursor_d = '0;
    end else if (cmd_i.cur_inc) begin
      cursor_d = cursor_q + CW'(1);
    end else if (cmd_i.cur_to_cnt) begin
      cursor_d = count_q;
    end
  end

  // Value field of the next result word.
  always_comb begin
    value_d = '0;
    case (cmd_i.vsel)
      uktab_pkg::V_KEY:   value_d = uktab_pkg::KEY_W'(key_q);
      uktab_pkg::V_RDATA: value_d = uktab_pkg::KEY_W'(rdata);
      default:            value_d = '0;
    endcase
  end

  // Status for the controller.
  assign stat_o.match    = (rdata == key_q);
  assign stat_o.last     = (cidx_nx == count_q);
  assign stat_o.cnt_zero = (count_q == '0);
  assign stat_o.full     = (count_q == CW'(DEPTH));
  assign stat_o.cur_end  = (cursor_q >= count_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      strobe_q <= cmd_i.emit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cidx_q <= cidx_d;
    if (cmd_i.ld_key) begin
      key_q <= key_in;
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      value_q  <= value_d;
      side_q   <= cmd_i.side_en && (rdata > key_q);
      last_q   <= cmd_i.last;
    end
  end

  assign result_strobe_o = strobe_q;
  assign status_o        = status_q;
  assign item_value_o    = value_q;
  assign split_side_o    = side_q;
  assign last_result_o   = last_q;
  assign entry_count_o   = uktab_pkg::CNT_OUT_W'(count_q);
  assign is_full_o       = stat_o.full;
  assign is_empty_o      = stat_o.cnt_zero;

endmodule

// ----- src/uktab_chk.sv -----
// Port-level checker for the unsorted key table, bound to the top level.
`timescale 1ns / 1ps

module uktab_chk #(
  parameter int DEPTH = uktab_pkg::DEPTH_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic [uktab_pkg::OP_W-1:0]      op_i,
  input logic [uktab_pkg::KEY_W-1:0]     key_value_i,
  input logic                            result_strobe_o,
  input logic [uktab_pkg::ST_W-1:0]      status_o,
  input logic [uktab_pkg::KEY_W-1:0]     item_value_o,
  input logic                            split_side_o,
  input logic                            last_result_o,
  input logic [uktab_pkg::CNT_OUT_W-1:0] entry_count_o,
  input logic                            is_full_o,
  input logic                            is_empty_o
);

  // An accepted command either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || result_strobe_o)
    else $error("accepted command neither answered nor started");

  // More words of a command are still to come, so the block stays busy.
  a_more_words_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !last_result_o |-> busy)
    else $error("non-final word while idle");

  // Any error status ends its command.
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (status_o != uktab_pkg::ST_OK) |-> last_result_o)
    else $error("error word not marked final");

  // A full refusal is only given by a full table.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (status_o == uktab_pkg::ST_FULL) |-> is_full_o && (DEPTH > 0))
    else $error("full status while table not full");

  // An empty split is only reported by an empty table.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (status_o == uktab_pkg::ST_EMPTY) |-> is_empty_o)
    else $error("empty status while table holds entries");

endmodule

bind unsorted_key_table uktab_chk #(.DEPTH(DEPTH)) u_chk (.*);

// ----- sim/tb_unsorted_key_table.sv -----
// Self-checking testbench for the unsorted key table: directed rows, then random episodes.
`timescale 1ns / 1ps

module tb_unsorted_key_table;

  localparam int OP_W      = uktab_pkg::OP_W;
  localparam int KEY_W     = uktab_pkg::KEY_W;
  localparam int ST_W      = uktab_pkg::ST_W;
  localparam int CNT_OUT_W = uktab_pkg::CNT_OUT_W;

  localparam int TBL_DEPTH = uktab_pkg::DEPTH_DEF;
  localparam logic [KEY_W-1:0] ITEM_MASK =
    {KEY_W{1'b1}} >> (KEY_W - uktab_pkg::ITEM_W_DEF);
  // Op codes the block does not define; it answers them with a plain ok word.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;
  // A delete-all of a full table of matches is the slowest command.
  localparam int SETTLE_CYCLES = 3 * TBL_DEPTH + 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int N_DIRECTED = 25;
  localparam int N_EPISODES = 18;
  localparam int EPISODE_LEN = 20;
  localparam int POOL_SIZE = 6;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      op_i;
  logic [KEY_W-1:0]     key_value_i;
  logic                 result_strobe_o;
  logic [ST_W-1:0]      status_o;
  logic [KEY_W-1:0]     item_value_o;
  logic                 split_side_o;
  logic                 last_result_o;
  logic [CNT_OUT_W-1:0] entry_count_o;
  logic                 is_full_o;
  logic                 is_empty_o;

  // One result word, in the order of the output ports.
  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [KEY_W-1:0]     value;
    logic                 side;
    logic                 last;
    logic [CNT_OUT_W-1:0] count;
    logic                 full;
    logic                 empty;
  } table_word_t;

  // One directed command; pinned rows carry their answer typed in.
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [KEY_W-1:0]     key;
    logic                 pinned;
    logic [ST_W-1:0]      status;
    logic [KEY_W-1:0]     value;
    logic [CNT_OUT_W-1:0] count;
  } dir_row_t;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{uktab_pkg::OP_READ,     16'h0000, 1'b1, uktab_pkg::ST_END,   16'h0000, 5'd0},
    '{uktab_pkg::OP_SPLIT,    16'h1234, 1'b1, uktab_pkg::ST_EMPTY, 16'h0000, 5'd0},
    '{uktab_pkg::OP_LOOKUP,   16'h0000, 1'b1, uktab_pkg::ST_MISS,  16'h0000, 5'd0},
    '{uktab_pkg::OP_DELETE,   16'hFFFF, 1'b1, uktab_pkg::ST_MISS,  16'h0000, 5'd0},
    '{uktab_pkg::OP_DEL_ALL,  16'h5A5A, 1'b1, uktab_pkg::ST_MISS,  16'h0000, 5'd0},
    '{uktab_pkg::OP_INSERT,   16'h0000, 1'b1, uktab_pkg::ST_OK,    16'h0000, 5'd1},
    '{uktab_pkg::OP_INSERT,   16'hFFFF, 1'b1, uktab_pkg::ST_OK,    16'h0000, 5'd2},
    '{uktab_pkg::OP_INSERT,   16'h8000, 1'b1, uktab_pkg::ST_OK,    16'h0000, 5'd3},
    '{uktab_pkg::OP_INS_UNIQ, 16'hFFFF, 1'b1, uktab_pkg::ST_DUP,   16'hFFFF, 5'd3},
    '{uktab_pkg::OP_INS_UNIQ, 16'h7FFF, 1'b1, uktab_pkg::ST_OK,    16'h0000, 5'd4},
    '{uktab_pkg::OP_INSERT,   16'h8000, 1'b1, uktab_pkg::ST_OK,    16'h0000, 5'd5},
    '{uktab_pkg::OP_LOOKUP,   16'hFFFF, 1'b1, uktab_pkg::ST_OK,    16'hFFFF, 5'd5},
    '{uktab_pkg::OP_SPLIT,    16'h7FFF, 1'b0, uktab_pkg::ST_OK,    16'h0000, 5'd0},
    '{uktab_pkg::OP_READ,     16'h0000, 1'b1, uktab_pkg::ST_END,   16'h0000, 5'd5},
    '{uktab_pkg::OP_CUR_RST,  16'hFFFF, 1'b1, uktab_pkg::ST_OK,    16'h0000, 5'd5},
    '{uktab_pkg::OP_READ,     16'h0000, 1'b1, uktab_pkg::ST_OK,    16'h0000, 5'd5},
    '{uktab_pkg::OP_DEL_ALL,  16'h8000, 1'b1, uktab_pkg::ST_OK,    16'h8000, 5'd3},
    '{uktab_pkg::OP_DELETE,   16'h0000, 1'b1, uktab_pkg::ST_OK,    16'h0000, 5'd2},
    '{uktab_pkg::OP_READ,     16'h0000, 1'b0, uktab_pkg::ST_OK,    16'h0000, 5'd0},
    '{uktab_pkg::OP_READ,     16'h0000, 1'b1, uktab_pkg::ST_END,   16'h0000, 5'd2},
    '{OP_SPARE_HI,            16'hFFFF, 1'b1, uktab_pkg::ST_OK,    16'h0000, 5'd2},
    '{OP_SPARE_LO,            16'h0001, 1'b1, uktab_pkg::ST_OK,    16'h0000, 5'd2},
    '{uktab_pkg::OP_CLEAR,    16'h0000, 1'b1, uktab_pkg::ST_OK,    16'h0000, 5'd0},
    '{uktab_pkg::OP_READ,     16'h0000, 1'b1, uktab_pkg::ST_END,   16'h0000, 5'd0},
    '{uktab_pkg::OP_SPLIT,    16'h0000, 1'b1, uktab_pkg::ST_EMPTY, 16'h0000, 5'd0}
  };

  // Shadow copy of the table and the words it still owes.
  logic [KEY_W-1:0] shadow_entries [TBL_DEPTH];
  int               shadow_fill;
  int               shadow_cursor;
  table_word_t      words_due [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  dir_row_t         pin_row;

  int n_cmds;
  int n_words;
  int n_split_words;
  int n_full_hits;
  int n_mismatch;
  int peak_fill;
  int quiet_cycles;

  unsorted_key_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .key_value_i    (key_value_i),
    .result_strobe_o(result_strobe_o),
    .status_o       (status_o),
    .item_value_o   (item_value_o),
    .split_side_o   (split_side_o),
    .last_result_o  (last_result_o),
    .entry_count_o  (entry_count_o),
    .is_full_o      (is_full_o),
    .is_empty_o     (is_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Queue one owed word; count and flags reflect the table after the command.
  function automatic void queue_word(input logic [ST_W-1:0] st, input logic [KEY_W-1:0] val,
                                     input logic side, input logic last);
    table_word_t w;
    w.status = st;
    w.value  = val;
    w.side   = side;
    w.last   = last;
    w.count  = CNT_OUT_W'(shadow_fill);
    w.full   = (shadow_fill == TBL_DEPTH);
    w.empty  = (shadow_fill == 0);
    if (st == uktab_pkg::ST_FULL) n_full_hits++;
    words_due.push_back(w);
  endfunction

  // Index of the first stored entry equal to the key, or the fill when absent.
  function automatic int find_first_match(input logic [KEY_W-1:0] key);
    for (int i = 0; i < shadow_fill; i++) begin
      if (shadow_entries[i] == key) return i;
    end
    return shadow_fill;
  endfunction

  // Apply one command to the shadow table and queue the words it produces.
  function automatic void apply_table_op(input logic [OP_W-1:0] op,
                                         input logic [KEY_W-1:0] key_in);
    logic [KEY_W-1:0] key;
    int               loc;
    int               i;
    bit               hit;
    key = key_in & ITEM_MASK;
    case (op)
      uktab_pkg::OP_INSERT: begin
        if (shadow_fill >= TBL_DEPTH) begin
          queue_word(uktab_pkg::ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          shadow_entries[shadow_fill] = key;
          shadow_fill++;
          queue_word(uktab_pkg::ST_OK, '0, 1'b0, 1'b1);
        end
      end
      uktab_pkg::OP_LOOKUP: begin
        loc = find_first_match(key);
        if (loc >= shadow_fill) queue_word(uktab_pkg::ST_MISS, '0, 1'b0, 1'b1);
        else queue_word(uktab_pkg::ST_OK, shadow_entries[loc], 1'b0, 1'b1);
      end
      uktab_pkg::OP_DELETE: begin
        loc = find_first_match(key);
        if (loc >= shadow_fill) begin
          queue_word(uktab_pkg::ST_MISS, '0, 1'b0, 1'b1);
        end else begin
          // The last entry fills the hole.
          shadow_entries[loc] = shadow_entries[shadow_fill - 1];
          shadow_fill--;
          queue_word(uktab_pkg::ST_OK, key, 1'b0, 1'b1);
        end
      end
      uktab_pkg::OP_CLEAR: begin
        shadow_fill = 0;
        queue_word(uktab_pkg::ST_OK, '0, 1'b0, 1'b1);
      end
      uktab_pkg::OP_CUR_RST: begin
        shadow_cursor = 0;
        queue_word(uktab_pkg::ST_OK, '0, 1'b0, 1'b1);
      end
      uktab_pkg::OP_READ: begin
        if (shadow_cursor >= shadow_fill) begin
          queue_word(uktab_pkg::ST_END, '0, 1'b0, 1'b1);
        end else begin
          queue_word(uktab_pkg::ST_OK, shadow_entries[shadow_cursor], 1'b0, 1'b1);
          shadow_cursor++;
        end
      end
      uktab_pkg::OP_SPLIT: begin
        if (shadow_fill == 0) begin
          queue_word(uktab_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < shadow_fill; i++) begin
            queue_word(uktab_pkg::ST_OK, shadow_entries[i], shadow_entries[i] > key,
                       i == shadow_fill - 1);
          end
          n_split_words += shadow_fill;
          shadow_cursor = shadow_fill;
        end
      end
      uktab_pkg::OP_INS_UNIQ: begin
        loc = find_first_match(key);
        if (loc < shadow_fill) begin
          queue_word(uktab_pkg::ST_DUP, shadow_entries[loc], 1'b0, 1'b1);
        end else if (shadow_fill >= TBL_DEPTH) begin
          queue_word(uktab_pkg::ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          shadow_entries[shadow_fill] = key;
          shadow_fill++;
          queue_word(uktab_pkg::ST_OK, '0, 1'b0, 1'b1);
        end
      end
      uktab_pkg::OP_DEL_ALL: begin
        // A moved-in entry is tested again before the scan moves on.
        hit = 1'b0;
        i = 0;
        while (i < shadow_fill) begin
          if (shadow_entries[i] == key) begin
            shadow_entries[i] = shadow_entries[shadow_fill - 1];
            shadow_fill--;
            hit = 1'b1;
          end else begin
            i++;
          end
        end
        if (hit) queue_word(uktab_pkg::ST_OK, key, 1'b0, 1'b1);
        else queue_word(uktab_pkg::ST_MISS, '0, 1'b0, 1'b1);
      end
      default: begin
        queue_word(uktab_pkg::ST_OK, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // Check result words and record accepted command words at each rising edge.
  always @(posedge clk_i) begin : port_watch
    table_word_t got;
    table_word_t owed;
    if (rst_ni) begin
      if (result_strobe_o) begin
        n_words++;
        got = '{status_o, item_value_o, split_side_o, last_result_o,
                entry_count_o, is_full_o, is_empty_o};
        if (words_due.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("%0t: result word with none owed", $realtime);
        end else begin
          owed = words_due.pop_front();
          if (got !== owed) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("%0t: want st=%0d val=%h side=%b last=%b cnt=%0d full=%b empty=%b",
                       $realtime, owed.status, owed.value, owed.side, owed.last,
                       owed.count, owed.full, owed.empty);
              $display("%0t: got  st=%0d val=%h side=%b last=%b cnt=%0d full=%b empty=%b",
                       $realtime, got.status, got.value, got.side, got.last,
                       got.count, got.full, got.empty);
            end
          end
        end
      end
      if (start && !busy) begin
        apply_table_op(op_i, key_value_i);
        // Directed rows with a typed answer replace the computed word.
        if (pin_row.pinned) begin
          owed.status = pin_row.status;
          owed.value  = pin_row.value;
          owed.side   = 1'b0;
          owed.last   = 1'b1;
          owed.count  = pin_row.count;
          owed.full   = (pin_row.count == TBL_DEPTH);
          owed.empty  = (pin_row.count == 0);
          words_due[words_due.size() - 1] = owed;
        end
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
        n_cmds++;
      end
    end
  end

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_strobe_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("unsorted_key_table verification failed");
        $finish;
      end
    end
  end

  // Present one command word at a falling edge and hold it until taken.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    int seen;
    seen = n_cmds;
    start       <= 1'b1;
    op_i        <= op;
    key_value_i <= key;
    do @(negedge clk_i); while (n_cmds == seen);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic maybe_idle(input bit calm);
    if (!calm && $urandom_range(0, 99) < 7) hold_off($urandom_range(1, 4));
  endtask

  // Stop sending until every owed word has come back, then let the block settle.
  task automatic drain_table();
    start <= 1'b0;
    while (words_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Mostly keys from a small pool so that searches hit; the rest anywhere.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return KEY_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Grow toward the episode's fill target, otherwise mix all operations.
  function automatic logic [OP_W-1:0] pick_op(input int target);
    int r;
    r = $urandom_range(0, 99);
    if (shadow_fill < target && r < 40) begin
      return (r < 28) ? uktab_pkg::OP_INSERT : uktab_pkg::OP_INS_UNIQ;
    end
    r = $urandom_range(0, 99);
    if (r < 10) return uktab_pkg::OP_INSERT;
    if (r < 18) return uktab_pkg::OP_INS_UNIQ;
    if (r < 32) return uktab_pkg::OP_LOOKUP;
    if (r < 44) return uktab_pkg::OP_DELETE;
    if (r < 52) return uktab_pkg::OP_DEL_ALL;
    if (r < 66) return uktab_pkg::OP_READ;
    if (r < 72) return uktab_pkg::OP_CUR_RST;
    if (r < 84) return uktab_pkg::OP_SPLIT;
    if (r < 87) return uktab_pkg::OP_CLEAR;
    if (r < 89) return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    return uktab_pkg::OP_INSERT;
  endfunction

  // Main sequence: reset, directed rows, random episodes, final drain.
  initial begin
    int  target;
    bit  calm;
    rst_ni        = 1'b0;
    start         = 1'b0;
    op_i          = uktab_pkg::OP_INSERT;
    key_value_i   = '0;
    pin_row       = '0;
    shadow_fill   = 0;
    shadow_cursor = 0;
    n_cmds        = 0;
    n_words       = 0;
    n_split_words = 0;
    n_full_hits   = 0;
    n_mismatch    = 0;
    peak_fill     = 0;
    quiet_cycles  = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      maybe_idle(1'b0);
      pin_row = dir_rows[i];
      send_word(dir_rows[i].op, dir_rows[i].key);
    end
    pin_row.pinned = 1'b0;
    drain_table();

    for (int ep = 0; ep < N_EPISODES; ep++) begin
      for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = KEY_W'($urandom_range(0, 16'hFFFF));
      if (ep % 4 == 0) begin
        key_pool[0] = '0;
        key_pool[1] = '1;
      end
      calm   = (ep >= 6 && ep <= 9);
      target = $urandom_range(1, TBL_DEPTH);
      // Every third episode first fills the table to the brim.
      if (ep % 3 == 0) begin
        target = TBL_DEPTH;
        while (shadow_fill < TBL_DEPTH) begin
          maybe_idle(calm);
          send_word(($urandom_range(0, 3) == 0) ? uktab_pkg::OP_INS_UNIQ
                                                 : uktab_pkg::OP_INSERT, pick_key());
        end
      end
      for (int k = 0; k < EPISODE_LEN; k++) begin
        maybe_idle(calm);
        send_word(pick_op(target), pick_key());
      end
      if (ep % 5 == 4) drain_table();
    end
    drain_table();

    $display("Run covered %0d commands and %0d result words, %0d of them from splits.",
             n_cmds, n_words, n_split_words);
    $display("Peak fill %0d of %0d, %0d full-table rejections, %0d mismatched words.",
             peak_fill, TBL_DEPTH, n_full_hits, n_mismatch);
    if (n_mismatch == 0 && words_due.size() == 0) begin
      $display("unsorted_key_table verification clean");
    end else begin
      $display("unsorted_key_table verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/uktab_pkg.sv
src/uktab_ram.sv
src/uktab_ctrl.sv
src/uktab_dp.sv
src/unsorted_key_table.sv
src/uktab_chk.sv
sim/tb_unsorted_key_table.sv
